[design/binary_grid_window_threshold_core_defines.svh]
// Assertion macros for the binary grid window threshold core.
// Taken in by the top level; no other dependencies.
`ifndef BINARY_GRID_WINDOW_THRESHOLD_CORE_DEFINES_SVH
`define BINARY_GRID_WINDOW_THRESHOLD_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BGWT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BGWT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bgwt_pkg.sv]
// Shared types, field widths, codes and tables of the window threshold core.
// No dependencies.
`timescale 1ns / 1ps

package bgwt_pkg;

    localparam int OP_W       = 2;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int ONES_W     = 6;
    localparam int DIM_W      = 7;
    localparam int RAD_W      = 2;
    localparam int THR_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int LIM_W      = THR_W + 8;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_EVAL   = 2'd1;
    localparam logic [OP_W-1:0] OP_COMMIT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd3;

    localparam logic [DIM_W-1:0] RST_MAP_WIDTH  = 7'd64;
    localparam logic [DIM_W-1:0] RST_MAP_HEIGHT = 7'd64;
    localparam logic [RAD_W-1:0] RST_RADIUS     = 2'd1;
    localparam logic [THR_W-1:0] RST_THRESHOLD  = 9'd128;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_EV_RD,
        S_EV_LAST,
        S_EV_WR,
        S_DONE
    } t_state;

    // Window area (2R+1)^2 for a radius of up to seven.
    function automatic logic [7:0] side_sq(input logic [2:0] rad);
        logic [7:0] sq;
        unique case (rad)
            3'd0: sq = 8'd1;
            3'd1: sq = 8'd9;
            3'd2: sq = 8'd25;
            3'd3: sq = 8'd49;
            3'd4: sq = 8'd81;
            3'd5: sq = 8'd121;
            3'd6: sq = 8'd169;
            3'd7: sq = 8'd225;
        endcase
        return sq;
    endfunction

endpackage

[design/bgwt_in_if.sv]
// Input channel of the window threshold core: valid/ready plus one command item.
// Depends on bgwt_pkg.
`timescale 1ns / 1ps

interface bgwt_in_if;
    import bgwt_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             cell_value;

    modport source (output valid, op, row, col, cell_value, input ready);
    modport sink   (input valid, op, row, col, cell_value, output ready);
endinterface

[design/bgwt_out_if.sv]
// Result channel of the window threshold core: valid/ready plus one result item.
// Depends on bgwt_pkg.
`timescale 1ns / 1ps

interface bgwt_out_if;
    import bgwt_pkg::*;

    logic              valid;
    logic              ready;
    logic              new_cell;
    logic [ONES_W-1:0] ones_in_window;

    modport source (output valid, new_cell, ones_in_window, input ready);
    modport sink   (input valid, new_cell, ones_in_window, output ready);
endinterface

[design/binary_grid_window_threshold_core.sv]
// Top level of the binary grid window threshold core: two map banks in RAM,
// command sequencer, result register. Depends on bgwt_pkg, bgwt_in_if,
// bgwt_out_if, bgwt_ram, bgwt_win_cnt and the assertion macro header.
//
//   channel   dir   handshake       payload
//   i_in      in    valid / ready   op, row, col, cell_value
//   o_out     out   valid / ready   new_cell, ones_in_window
//   i_cfg_*   in    write enable    i_cfg_idx, i_cfg_data
//
// Evaluate reads one row word of the window per cycle through the bank RAM port.
// Reset clears per-row valid flags at once; an unwritten row reads as zeros, no sweep.
// A finished result sits in the output register; the next item is taken meanwhile,
// and its own result waits in the last step until the register frees.
`timescale 1ns / 1ps
`include "binary_grid_window_threshold_core_defines.svh"

module binary_grid_window_threshold_core #(
    parameter int MAX_COLS   = 64,
    parameter int MAX_ROWS   = 64,
    parameter int MAX_RADIUS = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bgwt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bgwt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    bgwt_in_if.sink                            i_in,
    bgwt_out_if.source                         o_out
);
    import bgwt_pkg::*;

    localparam int RW       = $clog2(MAX_ROWS);
    localparam int CW       = $clog2(MAX_COLS);
    localparam int DMAX     = (RW > CW) ? RW : CW;
    localparam int AW       = ((DMAX > DIM_W) ? DMAX : DIM_W) + 2;
    localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
    localparam int RADW     = $clog2(MAX_RADIUS + 1);
    localparam int KW       = $clog2(SIDE_MAX);
    localparam int SW       = $clog2(SIDE_MAX + 1);
    localparam int CNTW     = $clog2(SIDE_MAX * SIDE_MAX + 1);

    // configuration
    logic [DIM_W-1:0] r_map_width;
    logic [DIM_W-1:0] r_map_height;
    logic [RAD_W-1:0] r_window_radius;
    logic [THR_W-1:0] r_threshold_q8;

    // control
    t_state              r_state, n_state;
    logic                r_cur_b;
    logic [MAX_ROWS-1:0] r_vld_a;
    logic [MAX_ROWS-1:0] r_vld_b;
    logic                r_out_valid;
    logic                r_p_vld;

    // item payload
    logic [AW-1:0]     r_row;
    logic [AW-1:0]     r_col;
    logic              r_val;
    logic [RADW-1:0]   r_rad;
    logic [AW-1:0]     r_w;
    logic [AW-1:0]     r_h;
    logic [LIM_W-1:0]  r_limit;
    logic [KW-1:0]     r_k;
    logic [CNTW-1:0]   r_acc;
    logic              r_p_in;
    logic              r_p_rvld;
    logic              r_res_bit;
    logic [ONES_W-1:0] r_res_cnt;
    logic              r_out_new;
    logic [ONES_W-1:0] r_out_ones;

    // accept-time values
    logic             in_acc;
    logic [AW-1:0]    eff_w;
    logic [AW-1:0]    eff_h;
    logic [RADW-1:0]  eff_rad;
    logic             in_inside;

    // window row walk
    logic [AW-1:0]    win_row;
    logic             win_in;
    logic [RW-1:0]    win_addr;
    logic [RW-1:0]    row_addr;
    logic [CW-1:0]    col_addr;
    logic [SW-1:0]    win_cnt;
    logic [SW-1:0]    side;
    logic [SW-1:0]    row_cnt;
    logic             eval_bit;
    logic             out_free;
    logic             res_load;

    // bank ports by role and by physical bank
    logic                cur_re, cur_we, nxt_re, nxt_we;
    logic [RW-1:0]       cur_raddr, cur_waddr, nxt_raddr, nxt_waddr;
    logic [MAX_COLS-1:0] cur_wdata, nxt_wdata, cur_rdata, nxt_rdata;
    logic [MAX_ROWS-1:0] cur_vld_vec, nxt_vld_vec;
    logic [MAX_COLS-1:0] cur_base, nxt_base, win_word;
    logic                re_a, we_a, re_b, we_b;
    logic [RW-1:0]       raddr_a, waddr_a, raddr_b, waddr_b;
    logic [MAX_COLS-1:0] wdata_a, wdata_b, rdata_a, rdata_b;

    assign in_acc = i_in.valid && i_in.ready;

    assign eff_w = (AW'(r_map_width) > AW'(MAX_COLS)) ? AW'(MAX_COLS) : AW'(r_map_width);
    assign eff_h = (AW'(r_map_height) > AW'(MAX_ROWS)) ? AW'(MAX_ROWS) : AW'(r_map_height);
    assign eff_rad = (32'(r_window_radius) > MAX_RADIUS) ? RADW'(MAX_RADIUS)
                                                         : RADW'(r_window_radius);
    assign in_inside = (AW'(i_in.row) < eff_h) && (AW'(i_in.col) < eff_w);

    assign win_row  = r_row + AW'(r_k) - AW'(r_rad);
    assign win_in   = !win_row[AW-1] && (win_row < r_h);
    assign win_addr = win_row[RW-1:0];
    assign row_addr = r_row[RW-1:0];
    assign col_addr = r_col[CW-1:0];

    assign cur_vld_vec = r_cur_b ? r_vld_b : r_vld_a;
    assign nxt_vld_vec = r_cur_b ? r_vld_a : r_vld_b;
    assign cur_rdata   = r_cur_b ? rdata_b : rdata_a;
    assign nxt_rdata   = r_cur_b ? rdata_a : rdata_b;
    assign cur_base    = cur_vld_vec[row_addr] ? cur_rdata : '0;
    assign nxt_base    = nxt_vld_vec[row_addr] ? nxt_rdata : '0;
    assign win_word    = r_p_rvld ? cur_rdata : '0;

    bgwt_win_cnt #(
        .MAX_COLS   (MAX_COLS),
        .MAX_RADIUS (MAX_RADIUS),
        .AW         (AW)
    ) u_win_cnt (
        .i_word  (win_word),
        .i_col   (r_col),
        .i_rad   (r_rad),
        .i_width (r_w),
        .o_count (win_cnt)
    );

    assign side     = SW'({r_rad, 1'b1});
    assign row_cnt  = r_p_in ? win_cnt : side;
    assign eval_bit = (LIM_W'({r_acc, 8'd0}) >= r_limit);
    assign out_free = !r_out_valid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority if (i_in.op == OP_LOAD && in_inside) begin
                        n_state = S_LD_RD;
                    end else if (i_in.op == OP_EVAL && in_inside) begin
                        n_state = S_EV_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_LD_RD:   n_state = S_LD_WR;
            S_LD_WR:   n_state = S_DONE;
            S_EV_RD: begin
                if (r_k == KW'({r_rad, 1'b0})) begin
                    n_state = S_EV_LAST;
                end
            end
            S_EV_LAST: n_state = S_EV_WR;
            S_EV_WR:   n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // state outputs: bank accesses by role
    always_comb begin
        logic [MAX_COLS-1:0] word;
        i_in.ready = 1'b0;
        res_load   = 1'b0;
        cur_re     = 1'b0;
        cur_raddr  = row_addr;
        cur_we     = 1'b0;
        cur_waddr  = row_addr;
        cur_wdata  = cur_base;
        nxt_re     = 1'b0;
        nxt_raddr  = row_addr;
        nxt_we     = 1'b0;
        nxt_waddr  = row_addr;
        nxt_wdata  = nxt_base;
        word       = '0;
        unique case (r_state)
            S_IDLE: i_in.ready = 1'b1;
            S_LD_RD: cur_re = 1'b1;
            S_LD_WR: begin
                word           = cur_base;
                word[col_addr] = r_val;
                cur_we         = 1'b1;
                cur_wdata      = word;
            end
            S_EV_RD: begin
                cur_re    = win_in;
                cur_raddr = win_addr;
                nxt_re    = (r_k == '0);
            end
            S_EV_LAST: ;
            S_EV_WR: begin
                word           = nxt_base;
                word[col_addr] = eval_bit;
                nxt_we         = 1'b1;
                nxt_wdata      = word;
            end
            S_DONE: res_load = out_free;
            default: ;
        endcase
    end

    // map roles onto the two physical banks
    assign re_a    = r_cur_b ? nxt_re    : cur_re;
    assign raddr_a = r_cur_b ? nxt_raddr : cur_raddr;
    assign we_a    = r_cur_b ? nxt_we    : cur_we;
    assign waddr_a = r_cur_b ? nxt_waddr : cur_waddr;
    assign wdata_a = r_cur_b ? nxt_wdata : cur_wdata;
    assign re_b    = r_cur_b ? cur_re    : nxt_re;
    assign raddr_b = r_cur_b ? cur_raddr : nxt_raddr;
    assign we_b    = r_cur_b ? cur_we    : nxt_we;
    assign waddr_b = r_cur_b ? cur_waddr : nxt_waddr;
    assign wdata_b = r_cur_b ? cur_wdata : nxt_wdata;

    bgwt_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr_a),
        .i_wdata (wdata_a),
        .i_re    (re_a),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    bgwt_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr_b),
        .i_wdata (wdata_b),
        .i_re    (re_b),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_cur_b         <= 1'b0;
            r_vld_a         <= '0;
            r_vld_b         <= '0;
            r_out_valid     <= 1'b0;
            r_p_vld         <= 1'b0;
            r_map_width     <= RST_MAP_WIDTH;
            r_map_height    <= RST_MAP_HEIGHT;
            r_window_radius <= RST_RADIUS;
            r_threshold_q8  <= RST_THRESHOLD;
        end else begin
            r_state     <= n_state;
            r_out_valid <= res_load || (r_out_valid && !o_out.ready);
            r_p_vld     <= (r_state == S_EV_RD);
            if (in_acc && i_in.op == OP_COMMIT) begin
                r_cur_b <= !r_cur_b;
            end
            if (we_a) begin
                r_vld_a[waddr_a] <= 1'b1;
            end
            if (we_b) begin
                r_vld_b[waddr_b] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAP_WIDTH:  r_map_width     <= i_cfg_data[DIM_W-1:0];
                    CFG_MAP_HEIGHT: r_map_height    <= i_cfg_data[DIM_W-1:0];
                    CFG_RADIUS:     r_window_radius <= i_cfg_data[RAD_W-1:0];
                    CFG_THRESHOLD:  r_threshold_q8  <= i_cfg_data[THR_W-1:0];
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_row     <= AW'(i_in.row);
            r_col     <= AW'(i_in.col);
            r_val     <= i_in.cell_value;
            r_rad     <= eff_rad;
            r_w       <= eff_w;
            r_h       <= eff_h;
            r_limit   <= LIM_W'(r_threshold_q8) * LIM_W'(side_sq(3'(eff_rad)));
            r_k       <= '0;
            r_acc     <= '0;
            r_res_bit <= 1'b0;
            r_res_cnt <= '0;
        end
        if (r_state == S_EV_RD) begin
            r_k      <= r_k + KW'(1);
            r_p_in   <= win_in;
            r_p_rvld <= cur_vld_vec[win_addr];
        end
        // fold the row word read last cycle into the window count
        if (r_p_vld) begin
            r_acc <= r_acc + CNTW'(row_cnt);
        end
        if (r_state == S_EV_WR) begin
            r_res_bit <= eval_bit;
            r_res_cnt <= ONES_W'(r_acc);
        end
        if (res_load) begin
            r_out_new  <= r_res_bit;
            r_out_ones <= r_res_cnt;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.new_cell       = r_out_new;
    assign o_out.ones_in_window = r_out_ones;

    `BGWT_ASSERT_SAME(a_one_bank_write, i_clk, i_rst_n, we_a, !we_b, "both banks written in one cycle")
    `BGWT_ASSERT_SAME(a_drained_before_write, i_clk, i_rst_n, r_state == S_EV_WR, !r_p_vld, "next bank written before window count finished")
    `BGWT_ASSERT_NEXT(a_roles_hold, i_clk, i_rst_n, r_state != S_IDLE, r_cur_b == $past(r_cur_b), "bank roles changed while an item is in work")
    `BGWT_ASSERT_NEXT(a_commit_swaps, i_clk, i_rst_n, in_acc && i_in.op == OP_COMMIT, r_cur_b != $past(r_cur_b), "commit did not swap banks")

endmodule

[design/bgwt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bgwt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[design/bgwt_win_cnt.sv]
// Counts the ones of one map row inside the column span of the window;
// columns outside the map count as ones. Depends on nothing but its parameters.
`timescale 1ns / 1ps

module bgwt_win_cnt #(
    parameter int MAX_COLS   = 64,
    parameter int MAX_RADIUS = 3,
    parameter int AW         = 9
) (
    input  logic [MAX_COLS-1:0]                   i_word,
    input  logic [AW-1:0]                         i_col,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]       i_rad,
    input  logic [AW-1:0]                         i_width,
    output logic [$clog2(2*MAX_RADIUS+2)-1:0]     o_count
);
    localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
    localparam int CW       = $clog2(MAX_COLS);
    localparam int SW       = $clog2(SIDE_MAX + 1);

    logic [SIDE_MAX-1:0] hit;

    always_comb begin
        logic [AW-1:0] cv;
        for (int d = 0; d < SIDE_MAX; d++) begin
            cv = i_col + AW'(d) - AW'(i_rad);
            if (AW'(d) > (AW'(i_rad) << 1)) begin
                hit[d] = 1'b0;
            end else if (cv[AW-1] || (cv >= i_width)) begin
                hit[d] = 1'b1;
            end else begin
                hit[d] = i_word[cv[CW-1:0]];
            end
        end
    end

    always_comb begin
        o_count = '0;
        for (int d = 0; d < SIDE_MAX; d++) begin
            o_count = o_count + SW'(hit[d]);
        end
    end
endmodule

[bench/grid_step_check.sv]
// Scoreboard for the binary grid window threshold core: mirrors both map banks,
// the bank select and the registers, predicts each result and compares it.
// Depends on bgwt_pkg, bgwt_in_if and bgwt_out_if.
`timescale 1ns / 1ps

module grid_step_check
    import bgwt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bgwt_in_if                    i_cmd,
    bgwt_out_if                   i_res,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int GRID_COLS   = 64;
    localparam int GRID_ROWS   = 64;
    localparam int GRID_RADIUS = 3;

    typedef struct packed {
        logic              new_cell;
        logic [ONES_W-1:0] ones;
    } cell_result_t;

    bit               grid_bank [2][GRID_ROWS][GRID_COLS];
    bit               cur_sel;
    logic [DIM_W-1:0] cfg_width;
    logic [DIM_W-1:0] cfg_height;
    logic [RAD_W-1:0] cfg_radius;
    logic [THR_W-1:0] cfg_threshold;
    cell_result_t     result_q[$];
    int               mismatches = 0;
    int               waiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Update the mirrored map for one item and return the result it should give.
    function automatic cell_result_t apply_cmd(input logic [OP_W-1:0] op,
                                               input logic [ROW_W-1:0] row,
                                               input logic [COL_W-1:0] col,
                                               input logic val);
        cell_result_t res;
        int w, h, rad, side, cnt, r, c;
        logic in_map;
        res = '0;
        w = (cfg_width > GRID_COLS) ? GRID_COLS : int'(cfg_width);
        h = (cfg_height > GRID_ROWS) ? GRID_ROWS : int'(cfg_height);
        rad = (cfg_radius > GRID_RADIUS) ? GRID_RADIUS : int'(cfg_radius);
        in_map = (int'(row) < h) && (int'(col) < w);
        case (op)
            OP_LOAD: begin
                if (in_map) grid_bank[cur_sel][row][col] = val;
            end
            OP_EVAL: begin
                if (in_map) begin
                    cnt = 0;
                    for (int dr = -rad; dr <= rad; dr++) begin
                        for (int dc = -rad; dc <= rad; dc++) begin
                            r = int'(row) + dr;
                            c = int'(col) + dc;
                            // off-map neighbors count as walls
                            if (r < 0 || r >= h || c < 0 || c >= w) cnt++;
                            else cnt += grid_bank[cur_sel][r][c];
                        end
                    end
                    side = 2 * rad + 1;
                    res.new_cell = (cnt * 256 >= int'(cfg_threshold) * side * side);
                    res.ones = cnt[ONES_W-1:0];
                    grid_bank[!cur_sel][row][col] = res.new_cell;
                end
            end
            OP_COMMIT: begin
                cur_sel = !cur_sel;
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        cell_result_t got, want;
        if (!i_rst_n) begin
            foreach (grid_bank[b, r, c]) grid_bank[b][r][c] = 1'b0;
            cur_sel = 1'b0;
            cfg_width = RST_MAP_WIDTH;
            cfg_height = RST_MAP_HEIGHT;
            cfg_radius = RST_RADIUS;
            cfg_threshold = RST_THRESHOLD;
            result_q.delete();
        end else begin
            // Retire first: an item's own result never leaves on its accept edge.
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.new_cell, i_res.ones_in_window};
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected result ones_in_window", got.ones, -1);
                end else begin
                    want = result_q.pop_front();
                    if (got.new_cell !== want.new_cell)
                        report_mismatch("new_cell", got.new_cell, want.new_cell);
                    if (got.ones !== want.ones)
                        report_mismatch("ones_in_window", got.ones, want.ones);
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                result_q.push_back(apply_cmd(i_cmd.op, i_cmd.row, i_cmd.col,
                                             i_cmd.cell_value));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAP_WIDTH:  cfg_width = i_cfg_data[DIM_W-1:0];
                    CFG_MAP_HEIGHT: cfg_height = i_cfg_data[DIM_W-1:0];
                    CFG_RADIUS:     cfg_radius = i_cfg_data[RAD_W-1:0];
                    CFG_THRESHOLD:  cfg_threshold = i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
        end
        waiting = result_q.size();
    end

endmodule

[bench/tb.sv]
// Top of the window threshold core bench: clock, reset, register writes,
// command stimulus and result backpressure, and the final verdict.
// Depends on bgwt_pkg, bgwt_in_if, bgwt_out_if, grid_step_check and the core.
`timescale 1ns / 1ps

module tb;
    import bgwt_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int SEGMENT_ITEMS = 90;
    localparam int GRID_DIM      = 64;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    cycles = 0;

    // per-segment register settings for the random part
    int seg_w[8] = '{8, 64, 6, 127, 3, 20, 64, 10};
    int seg_h[8] = '{8, 64, 12, 127, 3, 16, 64, 5};
    int seg_r[8] = '{1, 2, 3, 1, 0, 1, 3, 2};
    int seg_t[8] = '{128, 100, 200, 256, 128, 0, 160, 511};

    bgwt_in_if  cmd_ch ();
    bgwt_out_if res_ch ();

    binary_grid_window_threshold_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (cmd_ch),
        .o_out      (res_ch)
    );

    grid_step_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col, input logic val);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.op         <= op;
        cmd_ch.row        <= row;
        cmd_ch.col        <= col;
        cmd_ch.cell_value <= val;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every result, then let the core settle.
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(data);
    endtask

    task automatic set_grid(input int w, input int h, input int rad, input int thr);
        wait_idle();
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_MAP_HEIGHT, h);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_THRESHOLD, thr);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly items in a small hot area so windows fill up; some anywhere.
    task automatic run_segment(input int n_items, input int w, input int h);
        int we, he, span_r, span_c, base_r, base_c, pick;
        logic [OP_W-1:0]  op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        we = (w > GRID_DIM) ? GRID_DIM : w;
        he = (h > GRID_DIM) ? GRID_DIM : h;
        span_r = (he < 8) ? he : 8;
        span_c = (we < 8) ? we : 8;
        base_r = $urandom_range(he - span_r);
        base_c = $urandom_range(we - span_c);
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(99);
            if (pick < 45) op = OP_LOAD;
            else if (pick < 88) op = OP_EVAL;
            else if (pick < 97) op = OP_COMMIT;
            else op = OP_SPARE;
            if ($urandom_range(99) < 15) begin
                row = ROW_W'($urandom_range(GRID_DIM - 1));
                col = COL_W'($urandom_range(GRID_DIM - 1));
            end else begin
                row = ROW_W'(base_r + $urandom_range(span_r - 1));
                col = COL_W'(base_c + $urandom_range(span_c - 1));
            end
            send_cmd(op, row, col, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        cmd_ch.valid      = 1'b0;
        cmd_ch.op         = OP_LOAD;
        cmd_ch.row        = '0;
        cmd_ch.col        = '0;
        cmd_ch.cell_value = 1'b0;
        res_ch.ready      = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: corners and centre of an empty map, bank swaps
        send_cmd(OP_EVAL, 0, 0, 0);
        send_cmd(OP_EVAL, 63, 63, 0);
        send_cmd(OP_EVAL, 31, 31, 0);
        send_cmd(OP_LOAD, 0, 0, 1);
        send_cmd(OP_LOAD, 1, 1, 1);
        send_cmd(OP_EVAL, 1, 1, 0);
        send_cmd(OP_SPARE, 63, 63, 1);
        send_cmd(OP_COMMIT, 0, 0, 0);
        send_cmd(OP_EVAL, 0, 0, 0);
        send_cmd(OP_COMMIT, 63, 63, 1);

        // zero width: everything ignored
        set_grid(0, 64, 1, 128);
        send_cmd(OP_LOAD, 0, 0, 1);
        send_cmd(OP_EVAL, 0, 0, 0);

        // oversize dimensions clamp, single-cell window, zero threshold
        set_grid(127, 100, 0, 0);
        send_cmd(OP_EVAL, 63, 0, 0);
        send_cmd(OP_LOAD, 63, 63, 1);
        send_cmd(OP_EVAL, 63, 63, 0);

        // one-cell map, widest window, full threshold
        set_grid(1, 1, 3, 256);
        send_cmd(OP_EVAL, 0, 0, 0);
        send_cmd(OP_LOAD, 0, 0, 1);
        send_cmd(OP_EVAL, 0, 0, 0);
        send_cmd(OP_EVAL, 0, 1, 0);

        // threshold above the full ratio never fires
        set_grid(5, 5, 2, 511);
        send_cmd(OP_EVAL, 2, 2, 0);
        send_cmd(OP_LOAD, 4, 4, 1);
        send_cmd(OP_EVAL, 4, 4, 0);

        for (int p = 0; p < 4; p++) begin
            for (int s = 0; s < 2; s++) begin
                set_grid(seg_w[2*p+s], seg_h[2*p+s], seg_r[2*p+s], seg_t[2*p+s]);
                case (p)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                    default: begin send_idle_pct = 25; recv_stall_pct = 25; end
                endcase
                run_segment(SEGMENT_ITEMS, seg_w[2*p+s], seg_h[2*p+s]);
            end
        end

        wait_idle();
        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

endmodule

[binary_grid_window_threshold_core.f]
+incdir+design
design/bgwt_pkg.sv
design/bgwt_in_if.sv
design/bgwt_out_if.sv
design/bgwt_ram.sv
design/bgwt_win_cnt.sv
design/binary_grid_window_threshold_core.sv
bench/grid_step_check.sv
bench/tb.sv
